FILE: rtl/ptbe_pkg.sv
// ----------------------------------------------------------------------------
// ptbe_pkg: shared types and constants of the pointer tag bitmap engine
// Sizes of the tag store, granule arithmetic widths, the operation codes,
// the command passed from front to back and the back-end state encoding.
// ----------------------------------------------------------------------------
package ptbe_pkg;

    // tag store geometry: one tag bit per 8-byte granule, 64 tags per word
    localparam int BITMAP_WORDS = 1024;
    localparam int WORD_W       = 64;
    localparam int BIT_W        = 6;
    localparam int WORD_AW      = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

    // request field widths
    localparam int ADDR_W     = 19;
    localparam int SIZE_W     = 20;
    localparam int GRAN_SHIFT = 3;

    // granule arithmetic: wide enough for range ends, store size and sums
    localparam int GEND_W  = SIZE_W + 1 - GRAN_SHIFT;
    localparam int TOTAL_W = WORD_AW + BIT_W + 1;
    localparam int G_W     = ((TOTAL_W > GEND_W) ? TOTAL_W : GEND_W) + 1;
    localparam logic [G_W-1:0] GRAN_TOTAL = G_W'(BITMAP_WORDS * WORD_W);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef enum logic [1:0] {
        OP_MARK  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_COPY  = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    // classified command, word-level view of the request
    typedef struct packed {
        t_op                op;
        logic               noop;     // no store access, answer only
        logic               status;   // range beyond the store
        logic               nz;       // pointer nonzero (mark)
        logic               desc;     // copy walks words downward
        logic [WORD_AW-1:0] ws;       // first word of the range
        logic [WORD_AW-1:0] we;       // last word of the range
        logic [WORD_AW-1:0] wfirst;   // first word visited
        logic [WORD_AW-1:0] sfirst;   // low source word for wfirst
        logic [BIT_W-1:0]   sl;       // first granule bit in ws
        logic [BIT_W-1:0]   el;       // last granule bit in we
        logic [BIT_W-1:0]   sh;       // source bit offset for copy
    } t_cmd;

    // tag store port request from the back end
    typedef struct packed {
        logic               wr_en;
        logic [WORD_AW-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
        logic               rd_en;
        logic [WORD_AW-1:0] rd_addr;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_CLEAR  = 3'd0,
        S_IDLE   = 3'd1,
        S_RD_SHI = 3'd2,
        S_RD_DST = 3'd3,
        S_WRITE  = 3'd4,
        S_RESP   = 3'd5
    } t_back_state;

endpackage

FILE: rtl/ptbe_if.sv
// ----------------------------------------------------------------------------
// ptbe_if: request and response channels of the tag bitmap engine
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ptbe_in_if;
    import ptbe_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] dest_addr;
    logic [ADDR_W-1:0] src_addr;
    logic [SIZE_W-1:0] size_bytes;
    logic              pointer_nonzero;

    modport source (
        output valid, opcode, dest_addr, src_addr, size_bytes, pointer_nonzero,
        input  ready
    );
    modport sink (
        input  valid, opcode, dest_addr, src_addr, size_bytes, pointer_nonzero,
        output ready
    );
endinterface

interface ptbe_out_if;
    logic valid;
    logic ready;
    logic status;
    logic tag_bit;

    modport source (
        output valid, status, tag_bit,
        input  ready
    );
    modport sink (
        input  valid, status, tag_bit,
        output ready
    );
endinterface

FILE: rtl/pointer_tag_bitmap_engine.sv
// The single read port of the tag store paces the back end: mark and query
// read one word, flagged or empty requests none, clear one per word touched,
// copy three per destination word (two source reads and one destination
// read); the front may queue further requests while a range is walked.
// Reset: synchronous; the store is then swept to zero, one word per cycle,
// with the request channel not ready until every word is cleared.
// ----------------------------------------------------------------------------
// pointer_tag_bitmap_engine: shadow tag bitmap for pointer-holding granules
// Front classifies requests into a short command queue; the back end walks
// the tag store and returns one status/tag response per request.
// ----------------------------------------------------------------------------
module pointer_tag_bitmap_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptbe_in_if.sink    i_req,
    ptbe_out_if.source o_rsp
);
    import ptbe_pkg::*;

    t_cmd              front_cmd;
    t_cmd              head_cmd;
    t_mem_req          mem_req;
    logic [WORD_W-1:0] rd_data;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    logic              clearing;

    // request intake and classification
    ptbe_front u_front (
        .i_req      (i_req),
        .i_clearing (clearing),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    // decoupling queue
    ptbe_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    // store sequencer
    ptbe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_head     (head_cmd),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_mem      (mem_req),
        .i_rd_data  (rd_data),
        .o_rsp      (o_rsp)
    );

    // tag store
    ptbe_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BITMAP_WORDS)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_req.wr_en),
        .i_wr_addr (mem_req.wr_addr),
        .i_wr_data (mem_req.wr_data),
        .i_rd_en   (mem_req.rd_en),
        .i_rd_addr (mem_req.rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

FILE: rtl/ptbe_ram.sv
// ----------------------------------------------------------------------------
// ptbe_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ptbe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port, registered read port (old data on same-address access)
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/ptbe_front.sv
// ----------------------------------------------------------------------------
// ptbe_front: request intake and classification
// Range checks, no-op detection and word-level planning of each request.
// ----------------------------------------------------------------------------
module ptbe_front (
    ptbe_in_if.sink          i_req,
    input  logic             i_clearing,
    input  logic             i_q_full,
    output logic             o_push,
    output ptbe_pkg::t_cmd   o_cmd
);
    import ptbe_pkg::*;

    t_op              op;
    logic [SIZE_W:0]  byte_end;
    logic [G_W-1:0]   start_g;
    logic [G_W-1:0]   end_g;
    logic [G_W-1:0]   src_g;
    logic [G_W-1:0]   span;
    logic [G_W-1:0]   src_end;
    logic [G_W-1:0]   last_g;
    logic [G_W-1:0]   sbase;
    logic             bad_start;
    logic             bad_end;
    logic             bad_src;
    logic             single;
    logic             desc;
    logic [WORD_AW-1:0] ws;
    logic [WORD_AW-1:0] we;
    logic [WORD_AW-1:0] wfirst;

    // accept while the queue has room and the store is not being swept
    assign i_req.ready = !i_q_full && !i_clearing;
    assign o_push      = i_req.valid && i_req.ready;

    // granule range of the request
    assign op       = t_op'(i_req.opcode);
    assign byte_end = (SIZE_W+1)'(i_req.dest_addr) + (SIZE_W+1)'(i_req.size_bytes);
    assign start_g  = G_W'(i_req.dest_addr[ADDR_W-1:GRAN_SHIFT]);
    assign end_g    = G_W'(byte_end[SIZE_W:GRAN_SHIFT]);
    assign src_g    = G_W'(i_req.src_addr[ADDR_W-1:GRAN_SHIFT]);
    assign span     = end_g - start_g;
    assign src_end  = src_g + span;

    // bounds against the store size
    assign bad_start = (start_g >= GRAN_TOTAL);
    assign bad_end   = (end_g > GRAN_TOTAL);
    assign bad_src   = (src_end > GRAN_TOTAL);

    // word plan: mark and query touch one granule
    assign single = (op == OP_MARK) || (op == OP_QUERY);
    assign last_g = single ? start_g : (end_g - G_W'(1));
    assign ws     = start_g[WORD_AW+BIT_W-1:BIT_W];
    assign we     = last_g[WORD_AW+BIT_W-1:BIT_W];
    assign desc   = (op == OP_COPY) && (src_g < start_g);
    assign wfirst = desc ? we : ws;

    // low source word for the first visited word (two's complement, wraps)
    assign sbase = G_W'({wfirst, {BIT_W{1'b0}}}) + src_g - start_g;

    // command build
    always_comb begin
        o_cmd        = '0;
        o_cmd.op     = op;
        o_cmd.nz     = i_req.pointer_nonzero;
        o_cmd.desc   = desc;
        o_cmd.ws     = ws;
        o_cmd.we     = we;
        o_cmd.wfirst = wfirst;
        o_cmd.sfirst = sbase[WORD_AW+BIT_W-1:BIT_W];
        o_cmd.sl     = start_g[BIT_W-1:0];
        o_cmd.el     = last_g[BIT_W-1:0];
        o_cmd.sh     = src_g[BIT_W-1:0] - start_g[BIT_W-1:0];
        case (op)
            OP_MARK: begin
                o_cmd.status = bad_start;
                o_cmd.noop   = bad_start || !i_req.pointer_nonzero;
            end
            OP_CLEAR: begin
                o_cmd.status = bad_end;
                o_cmd.noop   = bad_end || (span == '0);
            end
            OP_COPY: begin
                o_cmd.status = bad_end || bad_src;
                o_cmd.noop   = bad_end || bad_src || (span == '0);
            end
            default: begin
                o_cmd.status = bad_start;
                o_cmd.noop   = bad_start;
            end
        endcase
    end

endmodule

FILE: rtl/ptbe_cmd_queue.sv
// ----------------------------------------------------------------------------
// ptbe_cmd_queue: short command queue between front and back
// Lets the front accept while the back is still walking a range.
// ----------------------------------------------------------------------------
module ptbe_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ptbe_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output ptbe_pkg::t_cmd o_head
);
    import ptbe_pkg::*;

    t_cmd            r_entries [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr;
    logic [QP_W:0]   r_count;
    logic [QP_W-1:0] n_wr_ptr;
    logic [QP_W-1:0] n_rd_ptr;
    logic [QP_W:0]   n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == (QP_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_entries[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QP_W'(QUEUE_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QP_W'(QUEUE_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entries[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/ptbe_back.sv
// ----------------------------------------------------------------------------
// ptbe_back: tag store sequencer
// Sweeps the store after reset, then runs commands word by word through
// read-modify-write and returns one response beat per command.
// ----------------------------------------------------------------------------
module ptbe_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  ptbe_pkg::t_cmd              i_head,
    output logic                        o_pop,
    output logic                        o_clearing,
    output ptbe_pkg::t_mem_req          o_mem,
    input  logic [ptbe_pkg::WORD_W-1:0] i_rd_data,
    ptbe_out_if.source                  o_rsp
);
    import ptbe_pkg::*;

    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    t_back_state        r_state;
    t_back_state        n_state;
    t_cmd               r_cmd;
    logic [WORD_AW-1:0] r_wd;
    logic [WORD_AW-1:0] r_sw;
    logic [WORD_AW-1:0] r_clr;
    logic [WORD_W-1:0]  r_src_lo;
    logic [WORD_W-1:0]  r_src_hi;
    logic               r_tag;
    logic               r_out_valid;
    logic               r_out_status;
    logic               r_out_tag;

    logic               out_free;
    logic               launch;
    logic               last_word;
    logic               clr_done;
    logic [WORD_AW-1:0] wd_next;
    logic [WORD_AW-1:0] sw_next;
    logic [WORD_AW-1:0] launch_addr;
    logic [WORD_W-1:0]  m_lo;
    logic [WORD_W-1:0]  m_hi;
    logic [WORD_W-1:0]  mask;
    logic [2*WORD_W-1:0] src_pair;
    logic [WORD_W-1:0]  src_word;
    logic [WORD_W-1:0]  new_word;
    logic               out_load;

    // shared control terms
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign launch      = !i_q_empty &&
                         ((r_state == S_IDLE) || ((r_state == S_RESP) && out_free));
    assign launch_addr = (i_head.op == OP_COPY) ? i_head.sfirst : i_head.wfirst;
    assign last_word   = (r_wd == (r_cmd.desc ? r_cmd.ws : r_cmd.we));
    assign wd_next     = r_cmd.desc ? (r_wd - 1'b1) : (r_wd + 1'b1);
    assign sw_next     = r_cmd.desc ? (r_sw - 1'b1) : (r_sw + 1'b1);
    assign clr_done    = (r_clr == WORD_AW'(BITMAP_WORDS-1));
    assign o_clearing  = (r_state == S_CLEAR);

    // granule mask of the current word
    assign m_lo = (r_wd == r_cmd.ws) ? (ALL_ONES << r_cmd.sl) : ALL_ONES;
    assign m_hi = (r_wd == r_cmd.we) ? (ALL_ONES >> (BIT_W'(WORD_W-1) - r_cmd.el))
                                     : ALL_ONES;
    assign mask = m_lo & m_hi;

    // source window for copy, aligned to the destination word
    assign src_pair = {r_src_hi, r_src_lo} >> r_cmd.sh;
    assign src_word = src_pair[WORD_W-1:0];

    // merged word for the write-back
    always_comb begin
        case (r_cmd.op)
            OP_MARK:  new_word = i_rd_data | mask;
            OP_CLEAR: new_word = i_rd_data & ~mask;
            OP_COPY:  new_word = (i_rd_data & ~mask) | (src_word & mask);
            default:  new_word = i_rd_data;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE, S_RESP: begin
                if (launch) begin
                    if (i_head.noop) begin
                        n_state = S_RESP;
                    end else if (i_head.op == OP_COPY) begin
                        n_state = S_RD_SHI;
                    end else begin
                        n_state = S_WRITE;
                    end
                end else if ((r_state == S_RESP) && out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RD_SHI: n_state = S_RD_DST;
            S_RD_DST: n_state = S_WRITE;
            S_WRITE: begin
                if (last_word) begin
                    n_state = S_RESP;
                end else if (r_cmd.op == OP_COPY) begin
                    n_state = S_RD_SHI;
                end else begin
                    n_state = S_WRITE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // store port and handshake outputs
    always_comb begin
        o_mem    = '0;
        o_pop    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_clr;
            end
            S_IDLE, S_RESP: begin
                out_load = (r_state == S_RESP) && out_free;
                if (launch) begin
                    o_pop         = 1'b1;
                    o_mem.rd_en   = !i_head.noop;
                    o_mem.rd_addr = launch_addr;
                end
            end
            S_RD_SHI: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = r_sw + 1'b1;
            end
            S_RD_DST: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = r_wd;
            end
            S_WRITE: begin
                o_mem.wr_en   = (r_cmd.op != OP_QUERY);
                o_mem.wr_addr = r_wd;
                o_mem.wr_data = new_word;
                // next word's first read overlaps this write-back
                o_mem.rd_en   = !last_word;
                o_mem.rd_addr = (r_cmd.op == OP_COPY) ? sw_next : wd_next;
            end
            default: begin
                o_mem = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // command, walk pointers and data holding registers
    always_ff @(posedge i_clk) begin
        if (launch) begin
            r_cmd <= i_head;
            r_wd  <= i_head.wfirst;
            r_sw  <= i_head.sfirst;
        end
        if (r_state == S_RD_SHI) begin
            r_src_lo <= i_rd_data;
        end
        if (r_state == S_RD_DST) begin
            r_src_hi <= i_rd_data;
        end
        if (r_state == S_WRITE) begin
            r_tag <= |(i_rd_data & mask);
            if (!last_word) begin
                r_wd <= wd_next;
                r_sw <= sw_next;
            end
        end
        if (out_load) begin
            r_out_status <= r_cmd.status;
            r_out_tag    <= (r_cmd.op == OP_QUERY) && !r_cmd.noop && r_tag;
        end
    end

    // response beat
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.status  = r_out_status;
    assign o_rsp.tag_bit = r_out_tag;

endmodule
